// ----- hw/rtl/hcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and codes for the Huffman code bit packer
// Holds the transaction payload structs, the command codes and the control
// bundle that the sequencer hands to the packing unit.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    // Command codes carried in the input transaction.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  symbol;
        logic [63:0] code_value;
        logic [6:0]  code_length;
    } item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // Start requests from the sequencer to the packing unit.
    typedef struct packed {
        logic start_encode;
        logic start_flush;
    } pk_ctrl_t;

endpackage

// ----- hw/rtl/hcbp_code_table.sv -----
// ----------------------------------------------------------------------------
// hcbp_code_table: code word and code length storage
// One write port and one read port with registered read data. Entries hold
// no defined value until they are loaded.
// ----------------------------------------------------------------------------
module hcbp_code_table #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 71,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/hcbp_packer.sv -----
// ----------------------------------------------------------------------------
// hcbp_packer: iterative bit packing unit
// Merges up to eight code bits per cycle into the partial byte through one
// shift-and-merge step; a completed byte waits for room in the output register.
// ----------------------------------------------------------------------------
module hcbp_packer #(
    parameter int MAX_CODE_BITS = 64,
    localparam int LW = $clog2(MAX_CODE_BITS + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hcbp_pkg::pk_ctrl_t       ctrl,
    input  logic [MAX_CODE_BITS-1:0] code,
    input  logic [LW-1:0]            length,
    output logic                     busy,
    output logic                     result_valid,
    input  logic                     result_stall,
    output hcbp_pkg::result_t        result
);

    import hcbp_pkg::*;

    logic                     busy_reg;
    logic                     flush_reg;
    logic [MAX_CODE_BITS-1:0] bits_reg;
    logic [LW-1:0]            remaining_reg;
    logic [7:0]               partial_reg;
    logic [2:0]               pending_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic          out_free;
    logic [3:0]    space;
    logic [3:0]    take;
    logic [7:0]    chunk;
    logic [7:0]    merged;
    logic [3:0]    fill;
    logic          full;
    logic [LW-1:0] rem_after;
    logic          step_go;
    logic          flush_go;

    // The output register can take a new byte when empty or being drained.
    assign out_free = !out_valid_reg || !result_stall;

    // Shared step: take as many bits as fit into the partial byte.
    always_comb
    begin
        space     = 4'd8 - {1'b0, pending_reg};
        take      = (remaining_reg < LW'(space)) ? 4'(remaining_reg) : space;
        chunk     = bits_reg[7:0] & 8'((9'd1 << take) - 9'd1);
        merged    = partial_reg | 8'({8'd0, chunk} << pending_reg);
        fill      = {1'b0, pending_reg} + take;
        full      = fill[3];
        rem_after = remaining_reg - LW'(take);
    end

    // A step that completes a byte waits for room in the output register.
    assign step_go  = busy_reg && !flush_reg && (!full || out_free);
    assign flush_go = busy_reg && flush_reg && out_free;

    // Sequencing of the accumulator and the bit shifter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            flush_reg     <= 1'b0;
            bits_reg      <= '0;
            remaining_reg <= '0;
            partial_reg   <= 8'd0;
            pending_reg   <= 3'd0;
        end
        else if (ctrl.start_encode)
        begin
            bits_reg      <= code;
            remaining_reg <= length;
            busy_reg      <= (length != '0);
            flush_reg     <= 1'b0;
        end
        else if (ctrl.start_flush)
        begin
            busy_reg  <= (pending_reg != 3'd0);
            flush_reg <= 1'b1;
        end
        else if (step_go)
        begin
            bits_reg      <= bits_reg >> take;
            remaining_reg <= rem_after;
            pending_reg   <= fill[2:0];
            partial_reg   <= full ? 8'd0 : merged;
            busy_reg      <= (rem_after != '0);
        end
        else if (flush_go)
        begin
            partial_reg <= 8'd0;
            pending_reg <= 3'd0;
            busy_reg    <= 1'b0;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((step_go && full) || flush_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload. A full byte is the last one when fewer than eight
    // bits remain, since those can no longer complete another byte.
    always_ff @(posedge clk)
    begin
        if (step_go && full)
        begin
            out_reg.out_byte <= merged;
            out_reg.last     <= (rem_after < LW'(8));
        end
        else if (flush_go)
        begin
            out_reg.out_byte <= partial_reg;
            out_reg.last     <= 1'b1;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A new command only arrives while the unit is idle.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.start_encode || ctrl.start_flush) |-> !busy_reg)
        else $error("packer started while busy");

    // An encode in progress always has bits left to place.
    a_encode_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !flush_reg) |-> (remaining_reg != '0))
        else $error("packer busy with no bits remaining");

    // A flush only runs with pending bits and leaves the accumulator empty.
    a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && flush_reg) |-> (pending_reg != 3'd0))
        else $error("flush running with nothing pending");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        flush_go |=> (pending_reg == 3'd0 && !busy_reg))
        else $error("flush did not clear the accumulator");

endmodule

// ----- hw/rtl/huffman_code_bit_packer.sv -----
// ----------------------------------------------------------------------------
// huffman_code_bit_packer: Huffman code table and bit packer
// Loads code words into a table, packs the codes of encoded symbols into
// bytes, earliest bit in bit 0, and flushes the partial byte on request.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and holds item_stall high until
// it has finished. A load is written to the table without leaving idle. A
// flush emits the partial byte when bits are pending. An encode does the
// registered table read, then one pass of the shared shift-and-merge step
// per chunk of up to eight bits, each pass completing at most one output
// byte, and then returns to idle to take the next transaction; a code of
// zero length places no bits. A pass that completes a byte waits while the
// output register is full and result_stall is high. The final byte caused
// by an encode or a flush carries last.
module huffman_code_bit_packer #(
    parameter int ALPHABET_SIZE = 256,
    parameter int MAX_CODE_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hcbp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output hcbp_pkg::result_t result
);

    import hcbp_pkg::*;

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int LW = $clog2(MAX_CODE_BITS + 1);
    localparam int EW = MAX_CODE_BITS + LW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic                     accept;
    logic                     in_range;
    logic [LW-1:0]            load_len;
    logic [MAX_CODE_BITS-1:0] load_code;
    logic                     wr_en;
    logic                     rd_en;
    logic [EW-1:0]            rd_data;
    pk_ctrl_t                 pk_ctrl;
    logic                     pk_busy;

    // Input handshake.
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign in_range   = ({1'b0, item.symbol} < 9'(ALPHABET_SIZE));

    // Saturate the code length and clear code bits above it on load.
    always_comb
    begin
        if (item.code_length > 7'(MAX_CODE_BITS))
        begin
            load_len = LW'(MAX_CODE_BITS);
        end
        else
        begin
            load_len = LW'(item.code_length);
        end
        for (int i = 0; i < MAX_CODE_BITS; i++)
        begin
            load_code[i] = item.code_value[i] && (LW'(i) < load_len);
        end
    end

    assign wr_en = accept && (item.cmd == CMD_LOAD) && in_range;
    assign rd_en = accept && (item.cmd == CMD_ENCODE) && in_range;

    hcbp_code_table #(
        .DEPTH (ALPHABET_SIZE),
        .WIDTH (EW)
    ) u_code_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (item.symbol[AW-1:0]),
        .wr_data ({load_len, load_code}),
        .rd_en   (rd_en),
        .rd_addr (item.symbol[AW-1:0]),
        .rd_data (rd_data)
    );

    // Start requests for the packing unit.
    assign pk_ctrl.start_encode = (state_reg == ST_READ);
    assign pk_ctrl.start_flush  = accept && (item.cmd == CMD_FLUSH);

    hcbp_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (pk_ctrl),
        .code         (rd_data[MAX_CODE_BITS-1:0]),
        .length       (rd_data[EW-1:MAX_CODE_BITS]),
        .busy         (pk_busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = ST_READ;
                end
                else if (pk_ctrl.start_flush)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_READ:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!pk_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An encode in the alphabet goes to the table read.
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_READ))
        else $error("encode did not start a table read");

    // The table read always hands over to the packing unit.
    a_read_to_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_RUN))
        else $error("table read not followed by packing");

    // The sequencer is never idle while the packing unit works.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pk_busy)
        else $error("sequencer idle while packer busy");

endmodule

// ----- verif/huffman_code_bit_packer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_test: self-checking bench for the code bit packer
// Loads code table entries, encodes symbols and flushes partial bytes through
// the valid/stall input channel, and checks every packed output byte and its
// last flag against a bit-level mirror of the table and the bit accumulator.
// Both channels idle and stall at random, with one long output hold-off and
// one full drain in the middle of the run.
// ----------------------------------------------------------------------------

// Mirror of the code tables and the bit accumulator, plus the queue of
// packed bytes that the block still owes.
class packed_byte_scoreboard;

    logic [63:0]       code_words [256];
    logic [6:0]        code_lens [256];
    logic [7:0]        partial_bits;
    int                pending_count;
    hcbp_pkg::result_t expected_bytes [$];
    int                mismatches;
    int                bytes_checked;
    int                loads_seen;
    int                encodes_seen;
    int                flushes_seen;

    function new();
        partial_bits   = '0;
        pending_count  = 0;
        mismatches     = 0;
        bytes_checked  = 0;
        loads_seen     = 0;
        encodes_seen   = 0;
        flushes_seen   = 0;
    endfunction

    function int outstanding();
        return expected_bytes.size();
    endfunction

    // Update the mirror with one accepted input transaction and queue the
    // bytes it completes; the final one carries last.
    function void absorb_item(hcbp_pkg::item_t it);
        logic [7:0]        fresh [$];
        logic [6:0]        len;
        logic [63:0]       keep_mask;
        hcbp_pkg::result_t res;

        case (it.cmd)
            hcbp_pkg::CMD_LOAD:
            begin
                loads_seen++;
                len = (it.code_length > 7'd64) ? 7'd64 : it.code_length;
                keep_mask = (len >= 7'd64) ? '1 : ((64'd1 << len) - 64'd1);
                code_lens[it.symbol]  = len;
                code_words[it.symbol] = it.code_value & keep_mask;
            end
            hcbp_pkg::CMD_ENCODE:
            begin
                encodes_seen++;
                for (int i = 0; i < code_lens[it.symbol]; i++)
                begin
                    partial_bits[pending_count] = code_words[it.symbol][i];
                    pending_count++;
                    if (pending_count == 8)
                    begin
                        fresh.push_back(partial_bits);
                        partial_bits  = '0;
                        pending_count = 0;
                    end
                end
            end
            hcbp_pkg::CMD_FLUSH:
            begin
                flushes_seen++;
                if (pending_count != 0)
                begin
                    fresh.push_back(partial_bits);
                    partial_bits  = '0;
                    pending_count = 0;
                end
            end
            default:
            begin
            end
        endcase

        foreach (fresh[i])
        begin
            res.out_byte = fresh[i];
            res.last     = (i == fresh.size() - 1);
            expected_bytes.push_back(res);
        end
    endfunction

    // Compare one accepted output transaction with the oldest expected byte.
    function void check_byte(hcbp_pkg::result_t got);
        hcbp_pkg::result_t want;

        if (expected_bytes.size() == 0)
        begin
            $error("unexpected output byte %02h (last %0d) with nothing pending",
                   got.out_byte, got.last);
            mismatches++;
            return;
        end
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (got.out_byte !== want.out_byte)
        begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   want.out_byte, got.out_byte);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
            mismatches++;
        end
    endfunction

endclass

module huffman_code_bit_packer_test;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 100;
    localparam int SETTLE_CYCLES   = 30;

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    hcbp_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    hcbp_pkg::result_t result;

    packed_byte_scoreboard scoreboard;
    logic [7:0]            loaded_syms [$];
    bit                    sym_loaded [256];
    bit                    quiet;
    bit                    hold_off_req;
    int                    cycle_count;

    huffman_code_bit_packer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;

        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic hcbp_pkg::item_t load_item(input logic [7:0] sym,
                                                  input logic [6:0] len,
                                                  input logic [63:0] word);
        hcbp_pkg::item_t it;

        it.cmd         = hcbp_pkg::CMD_LOAD;
        it.symbol      = sym;
        it.code_value  = word;
        it.code_length = len;
        return it;
    endfunction

    // Encode or flush; the unused fields carry random noise.
    function automatic hcbp_pkg::item_t op_item(input logic [1:0] cmd,
                                                input logic [7:0] sym);
        hcbp_pkg::item_t it;

        it.cmd         = cmd;
        it.symbol      = sym;
        it.code_value  = {$urandom, $urandom};
        it.code_length = 7'($urandom_range(0, 64));
        return it;
    endfunction

    // Offer one transaction and wait until it is taken, then idle a while.
    task automatic send_item(input hcbp_pkg::item_t it);
        int gap;

        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        scoreboard.absorb_item(it);
        if (it.cmd == hcbp_pkg::CMD_LOAD && !sym_loaded[it.symbol])
        begin
            sym_loaded[it.symbol] = 1'b1;
            loaded_syms.push_back(it.symbol);
        end
        gap = idle_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lower valid and wait until every expected byte has come back.
    task automatic drain();
        item_valid <= 1'b0;
        while (scoreboard.outstanding() != 0)
            @(posedge clk);
    endtask

    // One random transaction: mostly encodes of loaded symbols, some loads
    // with short codes and a few long ones, and some flushes.
    task automatic send_random();
        int         r;
        int         len_pick;
        logic [6:0] len;

        r = $urandom_range(0, 99);
        if (r < 22 || loaded_syms.size() == 0)
        begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 50)
                len = 7'($urandom_range(1, 8));
            else if (len_pick < 78)
                len = 7'($urandom_range(9, 20));
            else if (len_pick < 88)
                len = 7'd0;
            else
                len = 7'($urandom_range(21, 64));
            send_item(load_item(8'($urandom_range(0, 255)), len, {$urandom, $urandom}));
        end
        else if (r < 85)
            send_item(op_item(hcbp_pkg::CMD_ENCODE,
                              loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]));
        else
            send_item(op_item(hcbp_pkg::CMD_FLUSH, 8'($urandom_range(0, 255))));
    endtask

    // Output side: check each accepted byte and pick the next stall value.
    initial
    begin
        int stall_left;

        stall_left   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                scoreboard.check_byte(result);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            else if (stall_left == 0)
                stall_left = idle_gap();
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        scoreboard   = new();
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        rst_n        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: table extremes, zero length, aligned and unaligned
        // long codes, stray high code bits, flushes with and without bits.
        send_item(load_item(8'd0, 7'd0, '1));
        send_item(load_item(8'd255, 7'd64, '1));
        send_item(load_item(8'd1, 7'd1, 64'd1));
        send_item(load_item(8'd2, 7'd8, 64'hA5));
        send_item(load_item(8'd3, 7'd3, 64'hFFFF_FFFF_FFFF_FFFA));
        send_item(load_item(8'd128, 7'd64, 64'h0123_4567_89AB_CDEF));
        send_item(op_item(hcbp_pkg::CMD_FLUSH, 8'd0));
        send_item(op_item(hcbp_pkg::CMD_ENCODE, 8'd0));
        send_item(op_item(hcbp_pkg::CMD_ENCODE, 8'd2));
        send_item(op_item(hcbp_pkg::CMD_ENCODE, 8'd1));
        send_item(op_item(hcbp_pkg::CMD_ENCODE, 8'd255));
        send_item(op_item(hcbp_pkg::CMD_ENCODE, 8'd3));
        send_item(op_item(hcbp_pkg::CMD_FLUSH, 8'd255));
        send_item(op_item(hcbp_pkg::CMD_FLUSH, 8'd7));
        send_item(op_item(hcbp_pkg::CMD_ENCODE, 8'd128));
        send_item(load_item(8'd2, 7'd7, 64'hFFFF_FFFF_FFFF_FF5A));
        send_item(op_item(hcbp_pkg::CMD_ENCODE, 8'd2));
        send_item(op_item(hcbp_pkg::CMD_ENCODE, 8'd0));
        send_item(op_item(hcbp_pkg::CMD_ENCODE, 8'd255));
        send_item(op_item(hcbp_pkg::CMD_FLUSH, 8'd128));

        // Random part with a long output hold-off, a full drain and a
        // stretch with no idling on either side.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 35)
                hold_off_req = 1'b1;
            if (n == 60)
                drain();
            quiet = (n >= 75 && n < 95);
            send_random();
        end
        quiet = 1'b0;
        send_item(op_item(hcbp_pkg::CMD_FLUSH, 8'd0));

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d loads, %0d encodes and %0d flushes over %0d table entries;",
                 scoreboard.loads_seen, scoreboard.encodes_seen,
                 scoreboard.flushes_seen, loaded_syms.size());
        $display("checked %0d packed bytes in %0d cycles.",
                 scoreboard.bytes_checked, cycle_count);
        if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
